// File: rtl/swrmf_pkg.sv
// Package for the shallow water Rusanov mass flux block.
// Field widths, pipeline stage indexes and stage payload types.
// No dependencies.
`timescale 1ns / 1ps

package swrmf_pkg;

    // Field widths
    localparam int DATA_W  = 32;                 // input fields
    localparam int GRAV_W  = 24;                 // gravity register
    localparam int OUT_W   = 48;                 // mass_flux
    localparam int IN_TDATA_W  = 4 * DATA_W;
    localparam int OUT_TDATA_W = OUT_W;

    // Internal widths
    localparam int GH_W    = GRAV_W + DATA_W - 1; // g * max(h,0), below 2^55
    localparam int SQ_W    = GH_W + 1;            // root/remainder with headroom
    localparam int SQ_STEPS = (GH_W + 1) / 2;     // one root bit per stage
    localparam int ROOT_W  = SQ_STEPS;
    localparam int MAG_W   = DATA_W;              // |u|
    localparam int SPD_W   = MAG_W + 1;           // |u| + sqrt(g*h), wave speed
    localparam int DIFF_W  = DATA_W + 1;          // hR - hL
    localparam int Q_W     = 2 * DATA_W;          // u * h
    localparam int QSUM_W  = Q_W + 1;             // uL*hL + uR*hR
    localparam int PROD_W  = SPD_W + 1 + DIFF_W;  // c * (hR - hL), signed
    localparam int SUM_W   = PROD_W + 1;          // full flux sum

    // Pipeline stage indexes
    localparam int ST_P1      = 0;
    localparam int ST_SQ0     = 1;
    localparam int ST_SPD     = ST_SQ0 + SQ_STEPS;
    localparam int ST_MAX     = ST_SPD + 1;
    localparam int ST_MUL     = ST_MAX + 1;
    localparam int ST_SUM     = ST_MUL + 1;
    localparam int ST_OUT     = ST_SUM + 1;
    localparam int PIPE_DEPTH = ST_OUT + 1;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 24'd642908; // 9.81 in Q8.16

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Stage payloads
    typedef struct packed {
        logic        [GH_W-1:0]   gh_l;
        logic        [GH_W-1:0]   gh_r;
        logic signed [Q_W-1:0]    q_l;
        logic signed [Q_W-1:0]    q_r;
        logic        [MAG_W-1:0]  mag_l;
        logic        [MAG_W-1:0]  mag_r;
        logic signed [DIFF_W-1:0] diff;
        logic                     dry;
    } p1_t;

    typedef struct packed {
        logic        [SQ_W-1:0]   rem_l;
        logic        [SQ_W-1:0]   root_l;
        logic        [SQ_W-1:0]   rem_r;
        logic        [SQ_W-1:0]   root_r;
        logic        [MAG_W-1:0]  mag_l;
        logic        [MAG_W-1:0]  mag_r;
        logic signed [DIFF_W-1:0] diff;
        logic signed [QSUM_W-1:0] qsum;
        logic                     dry;
    } sq_t;

    typedef struct packed {
        logic        [SPD_W-1:0]  spd_l;
        logic        [SPD_W-1:0]  spd_r;
        logic signed [DIFF_W-1:0] diff;
        logic signed [QSUM_W-1:0] qsum;
        logic                     dry;
    } spd_t;

    typedef struct packed {
        logic        [SPD_W-1:0]  wave;
        logic signed [DIFF_W-1:0] diff;
        logic signed [QSUM_W-1:0] qsum;
        logic                     dry;
    } max_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [QSUM_W-1:0] qsum;
        logic                     dry;
    } mul_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic                     dry;
    } sum_t;

endpackage

// File: rtl/shallow_water_rusanov_mass_flux.sv
// Rusanov (local Lax-Friedrichs) mass flux for shallow water, fixed point.
// Throughput: one request per cycle unless back-pressure stalls; the 28-stage root pipeline is fully unrolled.
// Back-pressure stalls each stage only when it and all stages after it are full.
// Reset (aresetn low, synchronous) empties the pipe, holds s_tready low, loads gravity = 9.81.
// Depends on swrmf_pkg.
`timescale 1ns / 1ps

module shallow_water_rusanov_mass_flux
    import swrmf_pkg::*;
#(
    parameter int FRAC_BITS = 16              // fraction bits of all fields, 8..24
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    // gravity register, Q(FRAC_BITS) unsigned
    input  logic                     cfg_wr_en,
    input  logic [GRAV_W-1:0]        cfg_wr_data,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [31:0] vel_left, [63:32] vel_right, [95:64] depth_left, [127:96] depth_right
    input  logic [IN_TDATA_W-1:0]    s_tdata,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [47:0] mass_flux
    output logic [OUT_TDATA_W-1:0]   m_tdata
);

    // Rounding constant, half an output LSB at 2*FRAC_BITS fraction bits.
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [GRAV_W-1:0] gravity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= GRAVITY_RESET;
        end else if (cfg_wr_en) begin
            gravity_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control.
    // A stage takes new data when it is empty or the stage after it moves.
    // Valid bits travel with the payload; stalls never drop or repeat.
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [PIPE_DEPTH-1:0] adv;

    assign adv[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || m_tready;

    for (genvar i = 0; i < PIPE_DEPTH - 1; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_comb begin
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // no request is taken while reset is held
    assign s_tready = adv[ST_P1] && aresetn;
    assign m_tvalid = vld_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Stage P1: unpack, clamp depths under the root, all four multiplies.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] vel_left;
    logic signed [DATA_W-1:0] vel_right;
    logic signed [DATA_W-1:0] depth_left;
    logic signed [DATA_W-1:0] depth_right;

    assign vel_left    = s_tdata[DATA_W-1:0];
    assign vel_right   = s_tdata[2*DATA_W-1:DATA_W];
    assign depth_left  = s_tdata[3*DATA_W-1:2*DATA_W];
    assign depth_right = s_tdata[4*DATA_W-1:3*DATA_W];

    logic [DATA_W-2:0] hc_l;
    logic [DATA_W-2:0] hc_r;
    logic              dry_l;
    logic              dry_r;
    p1_t               p1_next;
    p1_t               p1_reg;

    function automatic logic [MAG_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + MAG_W'(1)) : v;
    endfunction

    always_comb begin
        // negative depth counts as zero under the root only
        hc_l  = depth_left[DATA_W-1]  ? '0 : depth_left[DATA_W-2:0];
        hc_r  = depth_right[DATA_W-1] ? '0 : depth_right[DATA_W-2:0];
        dry_l = depth_left[DATA_W-1]  || (depth_left == '0);
        dry_r = depth_right[DATA_W-1] || (depth_right == '0);

        p1_next.gh_l  = gravity_reg * hc_l;
        p1_next.gh_r  = gravity_reg * hc_r;
        p1_next.q_l   = vel_left * depth_left;
        p1_next.q_r   = vel_right * depth_right;
        p1_next.mag_l = mag(vel_left);
        p1_next.mag_r = mag(vel_right);
        p1_next.diff  = {depth_right[DATA_W-1], depth_right}
                      - {depth_left[DATA_W-1], depth_left};
        p1_next.dry   = dry_l && dry_r;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_P1]) begin
            p1_reg <= p1_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root pipeline: one result bit per stage on each side,
    // restoring method, test bit walks from 2^(2*SQ_STEPS-2) down to 1.
    // The first stage also forms uL*hL + uR*hR.
    // ------------------------------------------------------------------
    sq_t sq_in   [SQ_STEPS];
    sq_t sq_next [SQ_STEPS];
    sq_t sq_reg  [SQ_STEPS];

    function automatic sq_t sqrt_stage(input sq_t s, input logic [SQ_W-1:0] bitv);
        sq_t              r;
        logic [SQ_W-1:0]  trial_l;
        logic [SQ_W-1:0]  trial_r;
        r       = s;
        trial_l = s.root_l + bitv;
        trial_r = s.root_r + bitv;
        if (s.rem_l >= trial_l) begin
            r.rem_l  = s.rem_l - trial_l;
            r.root_l = (s.root_l >> 1) + bitv;
        end else begin
            r.root_l = s.root_l >> 1;
        end
        if (s.rem_r >= trial_r) begin
            r.rem_r  = s.rem_r - trial_r;
            r.root_r = (s.root_r >> 1) + bitv;
        end else begin
            r.root_r = s.root_r >> 1;
        end
        return r;
    endfunction

    assign sq_in[0] = '{
        rem_l:  {1'b0, p1_reg.gh_l},
        root_l: '0,
        rem_r:  {1'b0, p1_reg.gh_r},
        root_r: '0,
        mag_l:  p1_reg.mag_l,
        mag_r:  p1_reg.mag_r,
        diff:   p1_reg.diff,
        qsum:   {p1_reg.q_l[Q_W-1], p1_reg.q_l} + {p1_reg.q_r[Q_W-1], p1_reg.q_r},
        dry:    p1_reg.dry
    };

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] TEST_BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
        if (k > 0) begin : g_link
            assign sq_in[k] = sq_reg[k-1];
        end
        assign sq_next[k] = sqrt_stage(sq_in[k], TEST_BIT);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (adv[ST_SQ0 + k]) begin
                sq_reg[k] <= sq_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage SPD: side speeds |u| + sqrt(g*h)
    // ------------------------------------------------------------------
    spd_t spd_next;
    spd_t spd_reg;

    always_comb begin
        spd_next.spd_l = {1'b0, sq_reg[SQ_STEPS-1].mag_l}
                       + SPD_W'(sq_reg[SQ_STEPS-1].root_l[ROOT_W-1:0]);
        spd_next.spd_r = {1'b0, sq_reg[SQ_STEPS-1].mag_r}
                       + SPD_W'(sq_reg[SQ_STEPS-1].root_r[ROOT_W-1:0]);
        spd_next.diff  = sq_reg[SQ_STEPS-1].diff;
        spd_next.qsum  = sq_reg[SQ_STEPS-1].qsum;
        spd_next.dry   = sq_reg[SQ_STEPS-1].dry;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_SPD]) begin
            spd_reg <= spd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage MAX: wave speed c = max of the two sides
    // ------------------------------------------------------------------
    max_t max_next;
    max_t max_reg;

    always_comb begin
        max_next.wave = (spd_reg.spd_l >= spd_reg.spd_r) ? spd_reg.spd_l : spd_reg.spd_r;
        max_next.diff = spd_reg.diff;
        max_next.qsum = spd_reg.qsum;
        max_next.dry  = spd_reg.dry;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_MAX]) begin
            max_reg <= max_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage MUL: c * (hR - hL), 34 x 33 signed
    // ------------------------------------------------------------------
    logic signed [SPD_W:0] wave_s;
    mul_t                  mul_next;
    mul_t                  mul_reg;

    always_comb begin
        wave_s        = {1'b0, max_reg.wave};
        mul_next.prod = PROD_W'(wave_s * max_reg.diff);
        mul_next.qsum = max_reg.qsum;
        mul_next.dry  = max_reg.dry;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_MUL]) begin
            mul_reg <= mul_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage SUM: exact flux sum plus rounding half-LSB
    // ------------------------------------------------------------------
    sum_t sum_next;
    sum_t sum_reg;

    always_comb begin
        sum_next.sum = {{(SUM_W-QSUM_W){mul_reg.qsum[QSUM_W-1]}}, mul_reg.qsum}
                     - {mul_reg.prod[PROD_W-1], mul_reg.prod}
                     + RND;
        sum_next.dry = mul_reg.dry;
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_SUM]) begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage OUT: arithmetic shift by FRAC_BITS+1 (halving and rescale),
    // saturate to 48 bits, force zero when both sides are dry.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]   sum_s;
    logic signed [SUM_W-1:0]   shifted;
    logic [SUM_W-OUT_W:0]      top_bits;
    logic                      fits;
    logic [OUT_W-1:0]          out_data_next;
    logic [OUT_W-1:0]          out_data_reg;

    always_comb begin
        sum_s    = sum_reg.sum;
        shifted  = sum_s >>> (FRAC_BITS + 1);
        top_bits = shifted[SUM_W-1:OUT_W-1];
        fits     = (&top_bits) || !(|top_bits);
        if (sum_reg.dry) begin
            out_data_next = '0;
        end else if (fits) begin
            out_data_next = shifted[OUT_W-1:0];
        end else if (shifted[SUM_W-1]) begin
            out_data_next = OUT_MIN;
        end else begin
            out_data_next = OUT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_OUT]) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tdata = out_data_reg;

endmodule

// File: rtl/swrmf_checker.sv
// Port-level checker for the shallow water Rusanov mass flux block, and its bind.
// Depends on swrmf_pkg and shallow_water_rusanov_mass_flux.
`timescale 1ns / 1ps

module swrmf_checker
    import swrmf_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [IN_TDATA_W-1:0]    s_tdata,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_TDATA_W-1:0]   m_tdata
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    // consecutive cycles with m_tready high, saturating
    logic [CNT_W-1:0] rdy_run_reg;
    logic [CNT_W-1:0] rdy_run_next;
    logic             in_dry;
    logic             flowing;

    always_comb begin
        if (!m_tready) begin
            rdy_run_next = '0;
        end else if (rdy_run_reg == CNT_W'(PIPE_DEPTH)) begin
            rdy_run_next = rdy_run_reg;
        end else begin
            rdy_run_next = rdy_run_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdy_run_reg <= '0;
        end else begin
            rdy_run_reg <= rdy_run_next;
        end
    end

    assign in_dry = (s_tdata[3*DATA_W-1] || (s_tdata[3*DATA_W-1:2*DATA_W] == '0))
                 && (s_tdata[4*DATA_W-1] || (s_tdata[4*DATA_W-1:3*DATA_W] == '0));
    assign flowing = (rdy_run_reg == CNT_W'(PIPE_DEPTH));

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        flowing && $past(s_tvalid && s_tready, PIPE_DEPTH) |-> m_tvalid)
        else $error("result missing after pipeline latency");

    a_dry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        flowing && $past(s_tvalid && s_tready && in_dry, PIPE_DEPTH)
        |-> m_tvalid && (m_tdata == '0))
        else $error("dry interface gave nonzero flux");

endmodule

bind shallow_water_rusanov_mass_flux swrmf_checker u_swrmf_checker (.*);

// File: bench/shallow_water_rusanov_mass_flux_tb.sv
// Testbench for shallow_water_rusanov_mass_flux: directed vector table, then random requests
// under several gravity settings and handshake stall patterns, checked by a local flux model.
// Depends on swrmf_pkg and the block's RTL.
`timescale 1ns / 1ps

module shallow_water_rusanov_mass_flux_tb;
    import swrmf_pkg::*;

    localparam int FRAC = 16;
    localparam int PHASES = 6;
    localparam int PHASE_REQS = 315;
    localparam int HOLD_CYCLES = 300;       // long receiver hold, well past pipe depth
    localparam int TAIL_CYCLES = 60;        // leave room for strays

    // Handy Q16.16 / raw bit patterns
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [31:0] FX_ONE = 32'h0001_0000;
    localparam logic [23:0] G_ZERO = 24'h00_0000;
    localparam logic [23:0] G_FULL = 24'hFF_FFFF;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [GRAV_W-1:0]      cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [31:0] vel_left, [63:32] vel_right, [95:64] depth_left, [127:96] depth_right
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [47:0] mass_flux
    logic [OUT_TDATA_W-1:0] m_tdata;

    shallow_water_rusanov_mass_flux #(
        .FRAC_BITS(FRAC)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // 100 MHz
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Expected fluxes, oldest first; pushed by the request driver on accept.
    logic [OUT_W-1:0] flux_expect_q[$];
    int               err_count = 0;
    logic [GRAV_W-1:0] grav_now = GRAVITY_RESET;   // shadow of the gravity register

    // Stall rates in percent; receiver side is read by its own process.
    int s_idle_pct = 0;
    int r_idle_pct = 0;

    // Long receiver hold: main bumps hold_req, the receiver counts the stretch itself.
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    //------------------------------------------------------------------
    // Flux model
    //------------------------------------------------------------------

    // Floor square root, bit by bit from the top.
    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[31:0];
    endfunction

    // |u| + sqrt(g * max(h,0)); depth clamped only under the root
    function automatic logic [63:0] wave_speed(input logic signed [31:0] u,
                                               input logic signed [31:0] h,
                                               input logic [GRAV_W-1:0] g);
        longint      uw;
        logic [63:0] mag;
        logic [63:0] gh;
        uw = u;
        mag = (uw < 0) ? 64'(-uw) : 64'(uw);
        gh = (h > 0) ? 64'(g) * 64'(unsigned'(h)) : 64'd0;
        return mag + 64'(floor_sqrt(gh));
    endfunction

    function automatic logic [OUT_W-1:0] rusanov_flux(input logic [IN_TDATA_W-1:0] req,
                                                      input logic [GRAV_W-1:0] g);
        logic signed [31:0]  ul, ur, hl, hr;
        logic signed [127:0] ulw, urw, hlw, hrw, cw, acc, hi_lim, lo_lim;
        logic [63:0]         spd_l, spd_r;
        ul = req[31:0];
        ur = req[63:32];
        hl = req[95:64];
        hr = req[127:96];
        // dry interface on both sides
        if (hl <= 0 && hr <= 0)
            return '0;
        spd_l = wave_speed(ul, hl, g);
        spd_r = wave_speed(ur, hr, g);
        cw = (spd_l >= spd_r) ? spd_l : spd_r;     // zero-extended
        ulw = ul;
        urw = ur;
        hlw = hl;
        hrw = hr;
        // exact sum with 2*FRAC fraction bits, raw depths in both terms
        acc = ulw * hlw + urw * hrw - cw * (hrw - hlw);
        // halve and round to nearest, ties up
        acc = (acc + (128'sd1 <<< FRAC)) >>> (FRAC + 1);
        hi_lim = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
        lo_lim = -(128'sd1 <<< (OUT_W - 1));
        if (acc > hi_lim)
            return OUT_MAX;
        if (acc < lo_lim)
            return OUT_MIN;
        return acc[OUT_W-1:0];
    endfunction

    //------------------------------------------------------------------
    // Random field pickers
    //------------------------------------------------------------------

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(4))
            0: return S_MIN;
            1: return S_MAX;
            2: return 32'h0000_0001;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // mostly moderate speeds (|u| <= 30), some full-range and extremes
    function automatic logic [31:0] pick_vel();
        case ($urandom_range(7))
            0: return $urandom;
            1: return pick_extreme();
            default: return 32'(int'($urandom_range(0, 60 << 16)) - (30 << 16));
        endcase
    endfunction

    // mostly wet depths up to 200, with dry, negative and full-range cases
    function automatic logic [31:0] pick_depth();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'(-int'($urandom_range(1, 10 << 16)));
            2: return $urandom;
            3: return pick_extreme();
            default: return 32'($urandom_range(1, 200 << 16));
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_request();
        logic [31:0] vl, vr, hl, hr;
        vl = pick_vel();
        vr = pick_vel();
        hl = pick_depth();
        hr = pick_depth();
        // now and then force a dry interface: ~x of a non-negative value is negative
        if ($urandom_range(15) == 0) begin
            hl = hl[31] ? hl : ~hl;
            hr = hr[31] ? hr : ~hr;
        end
        return {hr, hl, vr, vl};
    endfunction

    //------------------------------------------------------------------
    // Driver tasks
    //------------------------------------------------------------------

    // Offer one request; on accept, queue its expected flux.
    task automatic offer(input logic [IN_TDATA_W-1:0] req, input bit fixed_exp,
                         input logic [OUT_W-1:0] fixed_flux);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        flux_expect_q.push_back(fixed_exp ? fixed_flux : rusanov_flux(req, grav_now));
    endtask

    // Stop offering and wait for every outstanding flux.
    task automatic wait_flux_drained();
        s_tvalid <= 1'b0;
        while (flux_expect_q.size() != 0)
            @(posedge aclk);
    endtask

    // Register write only with the pipe empty.
    task automatic write_gravity(input logic [GRAV_W-1:0] g);
        wait_flux_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        grav_now = g;
    endtask

    task automatic set_idling(input int s_pct, input int r_pct);
        s_idle_pct = s_pct;
        r_idle_pct <= r_pct;
    endtask

    //------------------------------------------------------------------
    // Directed vectors
    //------------------------------------------------------------------

    typedef struct packed {
        logic [GRAV_W-1:0] grav;
        logic [31:0]       vl;
        logic [31:0]       vr;
        logic [31:0]       hl;
        logic [31:0]       hr;
        logic              fixed_exp;   // flux typed in below, else from the model
        logic [OUT_W-1:0]  flux;
    } flux_vec_t;

    localparam int N_DIRECTED = 20;
    localparam flux_vec_t DIRECTED [N_DIRECTED] = '{
        // dry interfaces: zero result regardless of velocity
        '{GRAVITY_RESET, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 48'h0},
        '{GRAVITY_RESET, S_MAX, S_MIN, 32'h0, 32'h0, 1'b1, 48'h0},
        '{GRAVITY_RESET, S_MIN, S_MAX, S_MIN, 32'hFFFF_FFFF, 1'b1, 48'h0},
        '{GRAVITY_RESET, 32'h1234_5678, 32'hFFFF_FFFB, 32'hFFFF_0000, S_MIN, 1'b1, 48'h0},
        // wet, ordinary and extreme
        '{GRAVITY_RESET, FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1'b0, 48'h0},
        '{GRAVITY_RESET, S_MAX, S_MAX, S_MAX, S_MAX, 1'b0, 48'h0},
        '{GRAVITY_RESET, S_MIN, S_MIN, S_MAX, S_MAX, 1'b0, 48'h0},
        // one negative depth: clamped under the root, raw elsewhere
        '{GRAVITY_RESET, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFD_0000, 32'h0002_0000,
          1'b0, 48'h0},
        '{GRAVITY_RESET, 32'hFFFE_0000, 32'h0000_8000, 32'h0004_0000, 32'hFFFF_FFFF,
          1'b0, 48'h0},
        // smallest wet depth on each side
        '{GRAVITY_RESET, 32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 48'h0},
        '{GRAVITY_RESET, 32'h0, 32'h0, 32'h1, 32'h0, 1'b0, 48'h0},
        // rounding ties, no gravity: +0.5 LSB goes up, -0.5 LSB goes to zero
        '{G_ZERO, FX_ONE, 32'h0, 32'h1, 32'h1, 1'b1, 48'h1},
        '{G_ZERO, 32'hFFFF_0000, 32'h0, 32'h1, 32'h1, 1'b1, 48'h0},
        '{G_ZERO, 32'h0003_0000, 32'hFFFC_0000, 32'h0002_0000, 32'h0005_0000, 1'b0, 48'h0},
        // full gravity: both saturation rails
        '{G_FULL, S_MAX, S_MIN, S_MIN, S_MAX, 1'b1, OUT_MIN},
        '{G_FULL, S_MAX, S_MIN, S_MAX, S_MIN, 1'b1, OUT_MAX},
        '{G_FULL, 32'h0, 32'h0, S_MAX, S_MAX, 1'b0, 48'h0},
        '{G_FULL, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0F0F_0F0F, 32'h70F0_F0F0, 1'b0, 48'h0},
        // near the rails at default gravity
        '{GRAVITY_RESET, 32'h0, 32'h0, S_MAX, S_MIN, 1'b0, 48'h0},
        '{GRAVITY_RESET, S_MIN, S_MIN, S_MIN, 32'h1, 1'b0, 48'h0}
    };

    //------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold on request
    //------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    //------------------------------------------------------------------
    // Result checker
    //------------------------------------------------------------------
    logic [OUT_W-1:0] want_flux;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (flux_expect_q.size() == 0) begin
                $error("mass_flux: unexpected result %0d", $signed(m_tdata));
                err_count++;
            end else begin
                want_flux = flux_expect_q.pop_front();
                if (m_tdata !== want_flux) begin
                    $error("mass_flux mismatch: expected %0d, actual %0d",
                           $signed(want_flux), $signed(m_tdata));
                    err_count++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial begin
        logic [GRAV_W-1:0] phase_grav;
        flux_vec_t         v;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table under light sender stalls, heavy receiver stalls
        set_idling(13, 82);
        for (int i = 0; i < N_DIRECTED; i++) begin
            v = DIRECTED[i];
            if (v.grav != grav_now)
                write_gravity(v.grav);
            offer({v.hr, v.hl, v.vr, v.vl}, v.fixed_exp, v.flux);
        end

        // random phases; stall pattern flips every two phases, then none
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 2)
                0: set_idling(13, 82);
                1: set_idling(82, 13);
                default: set_idling(0, 0);
            endcase
            case (ph)
                0: phase_grav = GRAVITY_RESET;
                1: phase_grav = G_ZERO;
                2: phase_grav = G_FULL;
                4: phase_grav = 24'h00_0001;
                default: phase_grav = GRAV_W'($urandom);
            endcase
            write_gravity(phase_grav);
            for (int n = 0; n < PHASE_REQS; n++) begin
                // back-pressure the whole pipe while requests keep coming
                if ((ph == 1 && n == 100) || (ph == 4 && n == 50))
                    hold_req <= hold_req + 1;
                // sender pause until the pipe has emptied
                if (ph == 3 && n == 150)
                    wait_flux_drained();
                offer(random_request(), 1'b0, '0);
            end
        end

        wait_flux_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: times out far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/swrmf_pkg.sv
rtl/shallow_water_rusanov_mass_flux.sv
rtl/swrmf_checker.sv
bench/shallow_water_rusanov_mass_flux_tb.sv
